// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tts_pkg.sv
package tts_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUE      = 2'd2
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  task_id;
    logic [19:0] delay;
    logic [19:0] interval;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] due_id;
    logic       last;
  } out_t;

  // One slot entry as held in the slot memory.
  typedef struct packed {
    logic [7:0]  task_id;
    logic [31:0] deadline;
    logic [19:0] period;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_TK_RD,
    S_TK_EVAL,
    S_TK_DONE
  } state_e;

  typedef struct packed {
    logic slot_used;
    logic last_idx;
    logic due;
    logic cnt_full;
  } ctrl_stat_t;

  typedef struct packed {
    logic step;
    logic rd_en;
    logic ins_write;
    logic ins_full;
    logic fire;
    logic flush;
    logic busy;
  } ctrl_cmd_t;

endpackage

// File: sv/tts_ram.sv
module tts_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tts_ctrl.sv
module tts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic                tick_i,
  input  tts_pkg::ctrl_stat_t stat_i,
  output tts_pkg::ctrl_cmd_t  cmd_o
);
  import tts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc_i) begin
          state_d = (tick_i == KIND_TICK) ? S_TK_RD : S_INS_SCAN;
        end
      end
      S_INS_SCAN: begin
        if (!stat_i.slot_used || stat_i.last_idx) begin
          state_d = S_IDLE;
        end
      end
      S_TK_RD: begin
        if (stat_i.slot_used) begin
          state_d = S_TK_EVAL;
        end else if (stat_i.last_idx) begin
          state_d = S_TK_DONE;
        end
      end
      S_TK_EVAL: begin
        if ((stat_i.due && stat_i.cnt_full) || stat_i.last_idx) begin
          state_d = S_TK_DONE;
        end else begin
          state_d = S_TK_RD;
        end
      end
      S_TK_DONE: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o = '0;
      end
      S_INS_SCAN: begin
        cmd_o.busy      = 1'b1;
        cmd_o.ins_write = !stat_i.slot_used;
        cmd_o.ins_full  = stat_i.slot_used && stat_i.last_idx;
        cmd_o.step      = stat_i.slot_used && !stat_i.last_idx;
      end
      S_TK_RD: begin
        cmd_o.busy  = 1'b1;
        cmd_o.rd_en = stat_i.slot_used;
        cmd_o.step  = !stat_i.slot_used && !stat_i.last_idx;
      end
      S_TK_EVAL: begin
        cmd_o.busy = 1'b1;
        cmd_o.fire = stat_i.due;
        cmd_o.step = !(stat_i.due && stat_i.cnt_full) && !stat_i.last_idx;
      end
      S_TK_DONE: begin
        cmd_o.busy  = 1'b1;
        cmd_o.flush = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: sv/timer_task_scheduler.sv
// Timer slot table with periodic reload.
// Command channel: present req_i and raise start; the transaction is taken
// at the rising edge where start is high and busy is low. kind selects an
// insert (task id, delay, reload interval) or a one millisecond tick.
// Result channel: res_valid_o strobes for exactly one cycle per result and
// the receiver cannot stall it. An insert gives one result (accepted or
// table full), with last set. A tick gives one result per due task in
// ascending slot order, at most 16, last set on the final one; a tick with
// nothing due gives no result at all.
// Sequence: an insert walks the used flags from slot 0 to the first free slot
// (or to the last slot on a full table), then the result register. A tick
// visits every slot, stopping early once 16 tasks have fired: a free slot is
// stepped over, an occupied slot takes a memory read, then compare and write
// back, then closes out and registers the final result if anything fired.
// The single-port-read slot memory is why an occupied slot needs a read step.
// Reset clears the clock, all used flags and the controller; slot contents
// are left as they are and are only read behind a used flag.
module timer_task_scheduler #(
  parameter int unsigned SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tts_pkg::in_t  req_i,
  output logic          res_valid_o,
  output tts_pkg::out_t res_o
);
  import tts_pkg::*;

  localparam int unsigned IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_W = $bits(slot_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic              acc;
  ctrl_stat_t        stat;
  ctrl_cmd_t         cmd;

  logic [31:0]       time_q, time_d;
  logic [SLOTS-1:0]  used_q, used_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_valid_q, pend_valid_d;
  logic [7:0]        pend_id_q, pend_id_d;
  in_t               req_q;
  logic              res_valid_q, res_valid_d;
  out_t              res_q, res_d;

  slot_t             rd_slot, wr_slot;
  logic [SLOT_W-1:0] rd_raw;
  logic              ram_we;
  logic [31:0]       diff;

  // Transaction acceptance; busy also covers the cycle a final result sits
  // in the output register.
  assign acc  = start && !busy;
  assign busy = cmd.busy || res_valid_q;

  // Due when the wrapping difference now - deadline is not negative.
  assign rd_slot = slot_t'(rd_raw);
  assign diff    = time_q - rd_slot.deadline;

  assign stat.slot_used = used_q[idx_q];
  assign stat.last_idx  = (idx_q == LAST_IDX);
  assign stat.due       = !diff[31];
  assign stat.cnt_full  = (cnt_q == CNT_W'(MAX_RESULTS - 1));

  tts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .tick_i (req_i.kind),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Insert writes a fresh entry; a firing periodic slot writes back its
  // reloaded deadline. A one-shot slot only drops its used flag.
  always_comb begin
    if (cmd.ins_write) begin
      wr_slot.task_id  = req_q.task_id;
      wr_slot.deadline = time_q + {12'd0, req_q.delay};
      wr_slot.period   = req_q.interval;
    end else begin
      wr_slot.task_id  = rd_slot.task_id;
      wr_slot.deadline = rd_slot.deadline + {12'd0, rd_slot.period};
      wr_slot.period   = rd_slot.period;
    end
  end

  assign ram_we = cmd.ins_write || (cmd.fire && (rd_slot.period != '0));

  tts_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_slot),
    .re_i    (cmd.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );

  always_comb begin
    time_d       = time_q;
    used_d       = used_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;

    if (acc) begin
      idx_d        = '0;
      cnt_d        = '0;
      pend_valid_d = 1'b0;
      if (req_i.kind == KIND_TICK) begin
        time_d = time_q + 32'd1;
      end
    end
    if (cmd.step) begin
      idx_d = idx_q + IW'(1);
    end

    if (cmd.ins_write || cmd.ins_full) begin
      res_valid_d  = 1'b1;
      res_d.status = cmd.ins_write ? ST_ACCEPTED : ST_FULL;
      res_d.due_id = req_q.task_id;
      res_d.last   = 1'b1;
    end
    if (cmd.ins_write) begin
      used_d[idx_q] = 1'b1;
    end

    // Each due task is held back one find, so the final one can carry last.
    if (cmd.fire) begin
      if (rd_slot.period == '0) begin
        used_d[idx_q] = 1'b0;
      end
      cnt_d        = cnt_q + CNT_W'(1);
      pend_valid_d = 1'b1;
      pend_id_d    = rd_slot.task_id;
      if (pend_valid_q) begin
        res_valid_d  = 1'b1;
        res_d.status = ST_DUE;
        res_d.due_id = pend_id_q;
        res_d.last   = 1'b0;
      end
    end
    if (cmd.flush && pend_valid_q) begin
      res_valid_d  = 1'b1;
      res_d.status = ST_DUE;
      res_d.due_id = pend_id_q;
      res_d.last   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q       <= '0;
      used_q       <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      time_q       <= time_d;
      used_q       <= used_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
    if (acc) begin
      req_q <= req_i;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: sv/tts_checker.sv
`include "assert_macros.svh"

module tts_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          res_valid_o,
  input tts_pkg::out_t res_o
);
  import tts_pkg::*;

  // Every accepted transaction raises busy right after it is taken.
  `TTS_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, start && !busy, busy, "no busy after accept")
  // Results only appear while a transaction is in flight.
  `TTS_ASSERT(a_res_in_busy, clk_i, rst_ni, res_valid_o |-> busy, "result while idle")
  // Insert results stand alone.
  `TTS_ASSERT(a_ins_last, clk_i, rst_ni,
    res_valid_o && (res_o.status != ST_DUE) |-> res_o.last, "insert result without last")
  // Nothing follows the final result of a transaction directly.
  `TTS_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, res_valid_o && res_o.last, !res_valid_o,
    "result right after last")

endmodule

bind timer_task_scheduler tts_checker u_tts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// File: tb/sv/timer_task_scheduler_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the timer slot table.
// Commands go in at the falling edge and are taken at the rising edge where
// start is high and busy is low. Results are sampled at the rising edge
// while res_valid_o is high. A behavioral copy of the table (clock, used
// flags, ids, deadlines, periods) is updated for every transaction taken,
// and it queues the results that the block owes. The result monitor pops
// that queue in order.
module timer_task_scheduler_tb;
  import tts_pkg::*;

  localparam int unsigned SLOTS          = 16;
  // A tick visits every slot: read and compare per used one, plus close-out.
  localparam int unsigned SETTLE_CYCLES  = 2 * SLOTS + 8;
  // Worst case: a full-table tick with 16 results behind a long sender gap.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;
  // Slots that stay taken for the whole run: periodic, or due far ahead.
  localparam int unsigned MAX_STUCK      = 9;
  localparam logic [31:0] FAR_AHEAD      = 32'd5000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  in_t  req_i  = '0;
  logic busy;
  logic res_valid_o;
  out_t res_o;

  timer_task_scheduler #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Behavioral copy of the slot table
  // ---------------------------------------------------------------------
  logic [31:0] clock_ms;
  logic        slot_live    [SLOTS];
  logic [7:0]  slot_task_id [SLOTS];
  logic [31:0] slot_due     [SLOTS];
  logic [19:0] slot_period  [SLOTS];

  // Results the block still owes, oldest first.
  out_t awaited_events[$];

  int send_idle_pct = 0;
  int bad_results   = 0;
  int n_placed      = 0;
  int n_dropped     = 0;
  int n_ticks       = 0;
  int n_fired       = 0;
  int idle_cycles   = 0;

  // Apply one transaction to the table copy and queue the results it owes.
  function automatic void timer_table_step(input in_t t);
    int   free_idx;
    out_t r;
    out_t batch[$];
    logic [31:0] lag;
    free_idx = -1;
    if (t.kind == KIND_INSERT) begin
      // Lowest free slot wins; a full table drops the task untouched.
      for (int i = 0; i < SLOTS; i++)
        if (!slot_live[i] && free_idx < 0) free_idx = i;
      r.due_id = t.task_id;
      r.last   = 1'b1;
      if (free_idx < 0) begin
        r.status = ST_FULL;
        n_dropped++;
      end else begin
        slot_live[free_idx]    = 1'b1;
        slot_task_id[free_idx] = t.task_id;
        slot_due[free_idx]     = clock_ms + {12'd0, t.delay};
        slot_period[free_idx]  = t.interval;
        r.status = ST_ACCEPTED;
        n_placed++;
      end
      awaited_events = {awaited_events, r};
    end else begin
      // Time moves first, then every due slot fires once, in slot order.
      clock_ms = clock_ms + 32'd1;
      n_ticks++;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i] && batch.size() < MAX_RESULTS) begin
          lag = clock_ms - slot_due[i];
          if (!lag[31]) begin
            r.status = ST_DUE;
            r.due_id = slot_task_id[i];
            r.last   = 1'b0;
            batch = {batch, r};
            if (slot_period[i] != '0)
              slot_due[i] = slot_due[i] + {12'd0, slot_period[i]};
            else
              slot_live[i] = 1'b0;
          end
        end
      end
      // A tick with nothing due owes nothing.
      foreach (batch[k]) begin
        r = batch[k];
        r.last = (k == batch.size() - 1);
        awaited_events = {awaited_events, r};
        n_fired++;
      end
    end
  endfunction

  // Slots that will not free up within the run on their own.
  function automatic int stuck_slots();
    int cnt;
    cnt = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && (slot_period[i] != '0 || slot_due[i] - clock_ms > FAR_AHEAD))
        cnt++;
    return cnt;
  endfunction

  function automatic in_t insert_req(input logic [7:0] id, input logic [19:0] dly,
                                     input logic [19:0] per);
    in_t r;
    r.kind     = KIND_INSERT;
    r.task_id  = id;
    r.delay    = dly;
    r.interval = per;
    return r;
  endfunction

  // Tick payload fields are don't-care for the block, so fill them randomly.
  function automatic in_t tick_req();
    in_t r;
    r.kind     = KIND_TICK;
    r.task_id  = 8'($urandom_range(0, 255));
    r.delay    = 20'($urandom_range(0, 20'hFFFFF));
    r.interval = 20'($urandom_range(0, 20'hFFFFF));
    return r;
  endfunction

  // Mostly short one-shots so slots keep turning over; a few periodic or
  // far-off tasks until too many slots are pinned.
  function automatic in_t random_insert();
    int          roll;
    logic [19:0] dly;
    logic [19:0] per;
    roll = $urandom_range(0, 99);
    if (roll < 80)      dly = 20'($urandom_range(0, 30));
    else if (roll < 95) dly = 20'($urandom_range(0, 400));
    else                dly = 20'($urandom_range(0, 20'hFFFFF));
    per = '0;
    if ($urandom_range(0, 99) < 8) per = 20'($urandom_range(1, 60));
    if (stuck_slots() >= MAX_STUCK) begin
      per = '0;
      if (dly > 20'd400) dly = 20'($urandom_range(0, 30));
    end
    return insert_req(8'($urandom_range(0, 255)), dly, per);
  endfunction

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------
  // Drives one transaction, with random idle cycles ahead of it, and holds it
  // until taken. start stays high on return so back-to-back sends don't drop it.
  task automatic send_item(input in_t item);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
    timer_table_step(item);
  endtask

  // Stop sending, let every owed result arrive, then give the block time
  // to finish a tick that owes nothing.
  task automatic settle_block();
    @(negedge clk_i);
    start <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (awaited_events.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("[%0t] unexpected result: status %0d id %02h last %0b",
                   $time, res_o.status, res_o.due_id, res_o.last);
      end else begin
        want = awaited_events.pop_front();
        if (res_o.status !== want.status || res_o.due_id !== want.due_id ||
            res_o.last !== want.last) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("[%0t] mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                     $time, want.status, want.due_id, want.last,
                     res_o.status, res_o.due_id, res_o.last);
        end
      end
    end
  end

  // Watchdog: cycles with neither a command taken nor a result out.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // A zero-delay one-shot fires on the next tick, then a tick with nothing due.
  task automatic test_immediate_oneshot();
    send_item(insert_req(8'h00, 20'd0, 20'd0));
    send_item(tick_req());
    send_item(tick_req());
  endtask

  // Fill all slots, get refused, then fire all sixteen on one tick.
  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++)
      send_item(insert_req(8'h10 + 8'(i), (i == 0) ? 20'd0 : 20'd1, 20'd0));
    send_item(insert_req(8'hA5, 20'd3, 20'd0));
    send_item(tick_req());
  endtask

  // Extreme delay and period, a task reloading every tick, a slower reload.
  task automatic test_periodic_reload();
    send_item(insert_req(8'hFF, 20'hFFFFF, 20'hFFFFF));
    send_item(insert_req(8'h5A, 20'd0, 20'd1));
    send_item(insert_req(8'h3C, 20'd2, 20'd3));
    repeat (3) send_item(tick_req());
  endtask

  // Bursts of inserts followed by runs of ticks.
  task automatic test_random_traffic(input int idle_pct, input int items);
    int sent;
    int n_ins;
    int n_tk;
    send_idle_pct = idle_pct;
    sent = 0;
    while (sent < items) begin
      n_ins = $urandom_range(0, 8);
      n_tk  = $urandom_range(1, 6);
      repeat (n_ins) begin
        send_item(random_insert());
        sent++;
      end
      repeat (n_tk) begin
        send_item(tick_req());
        sent++;
      end
    end
  endtask

  initial begin
    clock_ms = '0;
    foreach (slot_live[i]) slot_live[i] = 1'b0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_immediate_oneshot();
    test_full_table();
    test_periodic_reload();
    settle_block();

    test_random_traffic(32, 145);
    settle_block();
    test_random_traffic(60, 145);
    settle_block();
    test_random_traffic(0, 145);
    settle_block();

    bad_results += awaited_events.size();
    $display("Covered %0d inserts placed, %0d refused on a full table, %0d ticks, %0d firings",
             n_placed, n_dropped, n_ticks, n_fired);
    $display("Sender idle rates 32%%, 60%% and none, with a full drain between phases");
    if (bad_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d bad results", bad_results);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
